// ----- sv/dalhs_pkg.sv -----
// ----------------------------------------------------------------------------
// dalhs_pkg
// Types and constants shared by the dual-axis link health supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package dalhs_pkg;

    // event codes
    typedef enum logic [2:0] {
        OP_RX_FRAME = 3'd0,
        OP_TX_DONE  = 3'd1,
        OP_POLL     = 3'd2,
        OP_MODE     = 3'd3,
        OP_CLEAR    = 3'd4,
        OP_FORGIVE  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_VELOCITY = 2'd1,
        MODE_POSITION = 2'd2,
        MODE_TORQUE   = 2'd3
    } t_mode;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_LEFT_NODE   = 3'd0,
        CFG_RIGHT_NODE  = 3'd1,
        CFG_LEFT_EN     = 3'd2,
        CFG_RIGHT_EN    = 3'd3,
        CFG_FB_TIMEOUT  = 3'd4,
        CFG_HB_TIMEOUT  = 3'd5,
        CFG_SETTLE      = 3'd6,
        CFG_STALL_LIMIT = 3'd7
    } t_cfg_idx;

    // frame decode
    localparam logic [4:0]  CMD_ENCODER   = 5'h09;
    localparam logic [4:0]  CMD_HB_REPORT = 5'h01;
    localparam logic [3:0]  ENC_MIN_LEN   = 4'd8;
    localparam logic [3:0]  HB_MIN_LEN    = 4'd5;
    localparam logic [7:0]  STATE_CLOSED  = 8'd8;
    localparam logic [15:0] RUN_TOP       = 16'hFFFF;

    // register reset values
    localparam logic [5:0]  RST_LEFT_NODE   = 6'd0;
    localparam logic [5:0]  RST_RIGHT_NODE  = 6'd1;
    localparam logic [15:0] RST_FB_TIMEOUT  = 16'd100;
    localparam logic [15:0] RST_HB_TIMEOUT  = 16'd500;
    localparam logic [15:0] RST_SETTLE      = 16'd500;
    localparam logic [15:0] RST_STALL_LIMIT = 16'd200;

    typedef struct packed {
        t_op         op;
        logic [31:0] now_ms;
        logic [5:0]  frame_node;
        logic [4:0]  frame_command;
        logic [3:0]  frame_length;
        logic [31:0] frame_word_low;
        logic [7:0]  frame_byte_four;
        logic        tx_direct;
        t_mode       new_mode;
    } t_evt;

    typedef struct packed {
        logic        left_healthy;
        logic        right_healthy;
        logic        stall_latched;
        logic        fault_dropped;
        t_mode       current_mode;
        logic [31:0] left_error_word;
        logic [31:0] right_error_word;
        logic        all_wheels_ok;
    } t_res;

    // per-axis link state
    typedef struct packed {
        logic [31:0] fb_time;
        logic        fb_seen;
        logic [31:0] hb_time;
        logic        hb_seen;
        logic [7:0]  drv_state;
        logic [31:0] error;
        logic        ok;
    } t_axis;

    // shared inputs of the per-axis health check
    typedef struct packed {
        logic        stall;
        logic        mode_active;
        logic        settling;
        logic [15:0] fb_timeout;
        logic [15:0] hb_timeout;
    } t_judge_ctl;

endpackage

`default_nettype wire

// ----- sv/dalhs_if.sv -----
// ----------------------------------------------------------------------------
// dalhs_evt_if / dalhs_res_if
// Valid/ready channels for event beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface dalhs_evt_if import dalhs_pkg::*; ();
    logic valid;
    logic ready;
    t_evt payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dalhs_res_if import dalhs_pkg::*; ();
    logic valid;
    logic ready;
    t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/dalhs_axis_judge.sv -----
// ----------------------------------------------------------------------------
// dalhs_axis_judge
// Fresh-and-confirmed check of one axis at a poll.
// ----------------------------------------------------------------------------
`default_nettype none

module dalhs_axis_judge import dalhs_pkg::*; (
    input  var t_axis      i_axis,
    input  var logic [31:0] i_now,
    input  var t_judge_ctl i_ctl,
    output var logic       o_ok
);

    logic [31:0] w_fb_age;
    logic [31:0] w_hb_age;
    logic        w_fresh;
    logic        w_confirmed;

    // ages wrap modulo 2^32
    assign w_fb_age = i_now - i_axis.fb_time;
    assign w_hb_age = i_now - i_axis.hb_time;
    assign w_fresh  = w_fb_age < {16'd0, i_ctl.fb_timeout};

    // heartbeat check; unseen heartbeats confirm without checks
    always_comb begin
        priority if (!i_axis.hb_seen) begin
            w_confirmed = 1'b1;
        end else if (w_hb_age >= {16'd0, i_ctl.hb_timeout}) begin
            w_confirmed = 1'b0;
        end else if (!i_ctl.mode_active || i_ctl.settling) begin
            w_confirmed = 1'b1;
        end else begin
            w_confirmed = (i_axis.drv_state == STATE_CLOSED);
        end
    end

    assign o_ok = i_axis.fb_seen && !i_ctl.stall && w_fresh && w_confirmed;

endmodule

`default_nettype wire

// ----- sv/dual_axis_link_health_supervisor_unit.sv -----
// ----------------------------------------------------------------------------
// dual_axis_link_health_supervisor_unit
// Link health supervisor for two motor axes on a CAN link.
// ----------------------------------------------------------------------------
// Usage:
//   i_evt carries one event beat (rx frame, tx outcome, poll, mode change,
//   clear errors, forgive staleness) with its millisecond timestamp.
//   o_res returns exactly one status beat per event, in order.
//   The config write port (i_cfg_valid/o_cfg_ready, index, data) is always
//   ready; write it only while no event is in flight.
// Pipeline and throughput:
//   An event is registered on accept, evaluated against the state, and its
//   status lands in the output register, which drives o_res.valid. One
//   event per cycle is sustained while o_res is ready; the evaluation stage
//   is one level of 32-bit subtract-and-compare logic.
// Stall:
//   While o_res is held off, one more event waits in the input register;
//   i_evt.ready drops once both registers are full.
// Reset:
//   Synchronous active-low. Axis state, deferral run, stall flag and mode
//   clear to zero/idle; config registers take their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_axis_link_health_supervisor_unit import dalhs_pkg::*; (
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    dalhs_evt_if.sink      i_evt,
    dalhs_res_if.source    o_res,
    input  var logic       i_cfg_valid,
    output var logic       o_cfg_ready,
    input  var t_cfg_idx   i_cfg_index,
    input  var logic [15:0] i_cfg_data
);

    // config registers
    logic [5:0]  r_left_node;
    logic [5:0]  r_right_node;
    logic        r_left_en;
    logic        r_right_en;
    logic [15:0] r_fb_timeout;
    logic [15:0] r_hb_timeout;
    logic [15:0] r_settle;
    logic [15:0] r_stall_limit;

    // state
    t_axis       r_left,  n_left;
    t_axis       r_right, n_right;
    logic [15:0] r_run,   n_run;
    logic        r_stall, n_stall;
    t_mode       r_mode,  n_mode;
    logic [31:0] r_mode_time, n_mode_time;

    // pipeline
    logic        r_in_valid;
    t_evt        r_in;
    logic        r_res_valid;
    t_res        r_res, n_res;
    logic        w_adv;

    t_judge_ctl  w_ctl;
    logic        w_left_ok;
    logic        w_right_ok;
    logic [31:0] w_settle_age;
    logic        w_left_bad;
    logic        w_right_bad;
    logic        w_dropped;

    assign o_cfg_ready = 1'b1;

    // handshake: evaluate when the output register is free or draining
    assign w_adv       = r_in_valid && (!r_res_valid || o_res.ready);
    assign i_evt.ready = !r_in_valid || w_adv;
    assign o_res.valid   = r_res_valid;
    assign o_res.payload = r_res;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_node   <= RST_LEFT_NODE;
            r_right_node  <= RST_RIGHT_NODE;
            r_left_en     <= 1'b1;
            r_right_en    <= 1'b1;
            r_fb_timeout  <= RST_FB_TIMEOUT;
            r_hb_timeout  <= RST_HB_TIMEOUT;
            r_settle      <= RST_SETTLE;
            r_stall_limit <= RST_STALL_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LEFT_NODE:   r_left_node   <= i_cfg_data[5:0];
                CFG_RIGHT_NODE:  r_right_node  <= i_cfg_data[5:0];
                CFG_LEFT_EN:     r_left_en     <= i_cfg_data[0];
                CFG_RIGHT_EN:    r_right_en    <= i_cfg_data[0];
                CFG_FB_TIMEOUT:  r_fb_timeout  <= i_cfg_data;
                CFG_HB_TIMEOUT:  r_hb_timeout  <= i_cfg_data;
                CFG_SETTLE:      r_settle      <= i_cfg_data;
                CFG_STALL_LIMIT: r_stall_limit <= i_cfg_data;
            endcase
        end
    end

    // health checks at a poll; the stall latched by this poll already counts
    assign w_settle_age    = r_in.now_ms - r_mode_time;
    assign w_ctl.stall       = r_stall || (r_run >= r_stall_limit);
    assign w_ctl.mode_active = (r_mode != MODE_IDLE);
    assign w_ctl.settling    = w_settle_age < {16'd0, r_settle};
    assign w_ctl.fb_timeout  = r_fb_timeout;
    assign w_ctl.hb_timeout  = r_hb_timeout;

    dalhs_axis_judge u_judge_left (
        .i_axis (r_left),
        .i_now  (r_in.now_ms),
        .i_ctl  (w_ctl),
        .o_ok   (w_left_ok)
    );

    dalhs_axis_judge u_judge_right (
        .i_axis (r_right),
        .i_now  (r_in.now_ms),
        .i_ctl  (w_ctl),
        .o_ok   (w_right_ok)
    );

    assign w_left_bad  = r_left_en && (!w_left_ok || (r_left.error != 32'd0));
    assign w_right_bad = r_right_en && (!w_right_ok || (r_right.error != 32'd0));

    // next state for the event in the input register
    always_comb begin
        n_left      = r_left;
        n_right     = r_right;
        n_run       = r_run;
        n_stall     = r_stall;
        n_mode      = r_mode;
        n_mode_time = r_mode_time;
        w_dropped   = 1'b0;

        unique case (r_in.op)
            OP_RX_FRAME: begin
                // equal node ids resolve to the left axis
                if (r_in.frame_node == r_left_node) begin
                    if (r_in.frame_command == CMD_ENCODER &&
                        r_in.frame_length >= ENC_MIN_LEN) begin
                        n_left.fb_time = r_in.now_ms;
                        n_left.fb_seen = 1'b1;
                    end else if (r_in.frame_command == CMD_HB_REPORT &&
                                 r_in.frame_length >= HB_MIN_LEN) begin
                        n_left.error     = r_in.frame_word_low;
                        n_left.drv_state = r_in.frame_byte_four;
                        n_left.hb_time   = r_in.now_ms;
                        n_left.hb_seen   = 1'b1;
                    end
                end else if (r_in.frame_node == r_right_node) begin
                    if (r_in.frame_command == CMD_ENCODER &&
                        r_in.frame_length >= ENC_MIN_LEN) begin
                        n_right.fb_time = r_in.now_ms;
                        n_right.fb_seen = 1'b1;
                    end else if (r_in.frame_command == CMD_HB_REPORT &&
                                 r_in.frame_length >= HB_MIN_LEN) begin
                        n_right.error     = r_in.frame_word_low;
                        n_right.drv_state = r_in.frame_byte_four;
                        n_right.hb_time   = r_in.now_ms;
                        n_right.hb_seen   = 1'b1;
                    end
                end
            end
            OP_TX_DONE: begin
                // saturating deferral run
                if (r_in.tx_direct) begin
                    n_run = 16'd0;
                end else if (r_run != RUN_TOP) begin
                    n_run = r_run + 16'd1;
                end
            end
            OP_POLL: begin
                n_stall    = w_ctl.stall;
                n_left.ok  = w_left_ok;
                n_right.ok = w_right_ok;
                if ((w_left_bad || w_right_bad) && r_mode != MODE_IDLE) begin
                    n_mode      = MODE_IDLE;
                    n_mode_time = r_in.now_ms;
                    w_dropped   = 1'b1;
                end
            end
            OP_MODE: begin
                n_mode      = r_in.new_mode;
                n_mode_time = r_in.now_ms;
            end
            OP_CLEAR: begin
                n_left.error  = 32'd0;
                n_right.error = 32'd0;
                n_stall       = 1'b0;
                n_run         = 16'd0;
            end
            OP_FORGIVE: begin
                n_left.fb_time  = r_in.now_ms;
                n_right.fb_time = r_in.now_ms;
                n_left.hb_time  = r_in.now_ms;
                n_right.hb_time = r_in.now_ms;
            end
            default: begin
                // unused codes only report status
            end
        endcase
    end

    // status from the updated state
    always_comb begin
        n_res.left_healthy     = n_left.ok;
        n_res.right_healthy    = n_right.ok;
        n_res.stall_latched    = n_stall;
        n_res.fault_dropped    = w_dropped;
        n_res.current_mode     = n_mode;
        n_res.left_error_word  = n_left.error;
        n_res.right_error_word = n_right.error;
        n_res.all_wheels_ok    =
            (!r_left_en || (n_left.ok && n_left.error == 32'd0)) &&
            (!r_right_en || (n_right.ok && n_right.error == 32'd0));
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            r_left      <= '0;
            r_right     <= '0;
            r_run       <= 16'd0;
            r_stall     <= 1'b0;
            r_mode      <= MODE_IDLE;
            r_mode_time <= 32'd0;
        end else begin
            if (i_evt.valid && i_evt.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end

            if (w_adv) begin
                r_res_valid <= 1'b1;
                r_left      <= n_left;
                r_right     <= n_right;
                r_run       <= n_run;
                r_stall     <= n_stall;
                r_mode      <= n_mode;
                r_mode_time <= n_mode_time;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_in <= i_evt.payload;
        end
        if (w_adv) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// ----- sv/dalhs_checker.sv -----
// ----------------------------------------------------------------------------
// dalhs_checker
// Port-level checks of the link health supervisor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dalhs_checker import dalhs_pkg::*; (
    input var logic i_clk,
    input var logic i_rst_n,
    input var logic i_res_valid,
    input var logic i_res_ready,
    input var t_res i_res
);

    // a held-off status beat keeps its contents
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res))
        else $error("status beat changed while stalled");

    // a fault drop always leaves the block idle
    a_drop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res.fault_dropped |-> i_res.current_mode == MODE_IDLE)
        else $error("fault drop without idle mode");

    // both axes healthy and error free means all wheels ok
    a_all_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res.left_healthy && i_res.right_healthy &&
        i_res.left_error_word == 32'd0 && i_res.right_error_word == 32'd0
        |-> i_res.all_wheels_ok)
        else $error("all_wheels_ok low with both axes healthy");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("status beat present after reset");

endmodule

bind dual_axis_link_health_supervisor_unit dalhs_checker u_dalhs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res       (o_res.payload)
);

`default_nettype wire

// ----- test/dual_axis_link_health_supervisor_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_axis_link_health_supervisor_unit_tb
// Self-checking bench for the dual-axis link health supervisor. A driver feeds
// event beats from a pending queue and a status model predicts each status
// beat when its event is accepted. A monitor compares every status beat,
// field by field, in order. Runs cover reset values, several register
// settings (extremes included), counter wrap of the millisecond clock, a
// deferral run past the stall limit, random back-pressure and long output
// stalls.
// ----------------------------------------------------------------------------
module dual_axis_link_health_supervisor_unit_tb;
    import dalhs_pkg::*;

    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  LONG_HOLD      = 80;
    localparam t_op OP_SPARE_A     = t_op'(3'd6);
    localparam t_op OP_SPARE_B     = t_op'(3'd7);

    // register image of the supervisor
    typedef struct packed {
        logic [5:0]  left_node;
        logic [5:0]  right_node;
        logic        left_en;
        logic        right_en;
        logic [15:0] fb_timeout;
        logic [15:0] hb_timeout;
        logic [15:0] settle;
        logic [15:0] stall_limit;
    } t_sup_settings;

    // tracked link state of one axis
    typedef struct packed {
        logic [31:0] fb_time;
        logic        fb_seen;
        logic [31:0] hb_time;
        logic        hb_seen;
        logic [7:0]  state;
        logic [31:0] err;
        logic        ok;
    } t_axis_track;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    t_cfg_idx    cfg_index;
    logic [15:0] cfg_data;

    dalhs_evt_if evt_if ();
    dalhs_res_if res_if ();

    dual_axis_link_health_supervisor_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt_if),
        .o_res       (res_if),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // status model state, starting from the reset image
    t_sup_settings active_settings = '{left_node: RST_LEFT_NODE,
                                       right_node: RST_RIGHT_NODE,
                                       left_en: 1'b1, right_en: 1'b1,
                                       fb_timeout: RST_FB_TIMEOUT,
                                       hb_timeout: RST_HB_TIMEOUT,
                                       settle: RST_SETTLE,
                                       stall_limit: RST_STALL_LIMIT};
    t_axis_track   track_l        = '0;
    t_axis_track   track_r        = '0;
    logic [15:0]   deferral_count = '0;
    logic          stall_latch    = 1'b0;
    t_mode         mode_now       = MODE_IDLE;
    logic [31:0]   mode_since     = '0;

    t_evt pending_events[$];
    t_res expected_status[$];

    logic [31:0] event_clock;
    int          sender_idle_pct;
    int          receiver_idle_pct;
    int          hold_left       = 0;
    int          quiet_cycles    = 0;
    int          events_accepted = 0;
    int          status_checked  = 0;
    int          mismatches      = 0;
    int          drops_predicted = 0;
    int          stalled_polls   = 0;
    int          settings_loaded;

    // ------------------------------------------------------------------
    // status model
    // ------------------------------------------------------------------
    function automatic t_axis_track absorb_frame(input t_axis_track a, input t_evt e);
        if (e.frame_command == CMD_ENCODER && e.frame_length >= ENC_MIN_LEN) begin
            a.fb_time = e.now_ms;
            a.fb_seen = 1'b1;
        end else if (e.frame_command == CMD_HB_REPORT && e.frame_length >= HB_MIN_LEN) begin
            a.err     = e.frame_word_low;
            a.state   = e.frame_byte_four;
            a.hb_time = e.now_ms;
            a.hb_seen = 1'b1;
        end
        return a;
    endfunction

    // fresh feedback, no stall, and heartbeat confirms closed loop
    function automatic logic axis_healthy(input t_axis_track a, input logic [31:0] now);
        logic [31:0] fb_age;
        logic [31:0] hb_age;
        logic [31:0] settle_age;
        logic        confirmed;
        fb_age     = now - a.fb_time;
        hb_age     = now - a.hb_time;
        settle_age = now - mode_since;
        if (!a.hb_seen)
            confirmed = 1'b1;
        else if (hb_age >= {16'd0, active_settings.hb_timeout})
            confirmed = 1'b0;
        else if (mode_now == MODE_IDLE)
            confirmed = 1'b1;
        else if (settle_age < {16'd0, active_settings.settle})
            confirmed = 1'b1;
        else
            confirmed = (a.state == STATE_CLOSED);
        return a.fb_seen && !stall_latch && (fb_age < {16'd0, active_settings.fb_timeout})
               && confirmed;
    endfunction

    function automatic t_res supervise_event(input t_evt e);
        t_res r;
        logic lbad;
        logic rbad;
        logic dropped;
        dropped = 1'b0;
        case (e.op)
            OP_RX_FRAME: begin
                // equal node ids: left axis wins
                if (e.frame_node == active_settings.left_node)
                    track_l = absorb_frame(track_l, e);
                else if (e.frame_node == active_settings.right_node)
                    track_r = absorb_frame(track_r, e);
            end
            OP_TX_DONE: begin
                if (e.tx_direct)
                    deferral_count = '0;
                else if (deferral_count != RUN_TOP)
                    deferral_count = deferral_count + 16'd1;
            end
            OP_POLL: begin
                if (deferral_count >= active_settings.stall_limit)
                    stall_latch = 1'b1;
                track_l.ok = axis_healthy(track_l, e.now_ms);
                track_r.ok = axis_healthy(track_r, e.now_ms);
                lbad = active_settings.left_en && (!track_l.ok || track_l.err != '0);
                rbad = active_settings.right_en && (!track_r.ok || track_r.err != '0);
                if ((lbad || rbad) && mode_now != MODE_IDLE) begin
                    mode_now   = MODE_IDLE;
                    mode_since = e.now_ms;
                    dropped    = 1'b1;
                end
            end
            OP_MODE: begin
                mode_now   = e.new_mode;
                mode_since = e.now_ms;
            end
            OP_CLEAR: begin
                track_l.err    = '0;
                track_r.err    = '0;
                stall_latch    = 1'b0;
                deferral_count = '0;
            end
            OP_FORGIVE: begin
                track_l.fb_time = e.now_ms;
                track_r.fb_time = e.now_ms;
                track_l.hb_time = e.now_ms;
                track_r.hb_time = e.now_ms;
            end
            default: ;
        endcase
        r.left_healthy     = track_l.ok;
        r.right_healthy    = track_r.ok;
        r.stall_latched    = stall_latch;
        r.fault_dropped    = dropped;
        r.current_mode     = mode_now;
        r.left_error_word  = track_l.err;
        r.right_error_word = track_r.err;
        r.all_wheels_ok    = (!active_settings.left_en || (track_l.ok && track_l.err == '0))
                          && (!active_settings.right_en || (track_r.ok && track_r.err == '0));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // event builders
    // ------------------------------------------------------------------
    function automatic t_evt simple_evt(input t_op op, input logic [31:0] now);
        t_evt e;
        e        = '0;
        e.op     = op;
        e.now_ms = now;
        return e;
    endfunction

    function automatic t_evt frame_evt(input logic [31:0] now, input logic [5:0] node,
                                       input logic [4:0] cmd, input logic [3:0] len,
                                       input logic [31:0] word, input logic [7:0] state);
        t_evt e;
        e                 = simple_evt(OP_RX_FRAME, now);
        e.frame_node      = node;
        e.frame_command   = cmd;
        e.frame_length    = len;
        e.frame_word_low  = word;
        e.frame_byte_four = state;
        return e;
    endfunction

    function automatic t_evt tx_evt(input logic [31:0] now, input logic direct);
        t_evt e;
        e           = simple_evt(OP_TX_DONE, now);
        e.tx_direct = direct;
        return e;
    endfunction

    function automatic t_evt mode_evt(input logic [31:0] now, input t_mode m);
        t_evt e;
        e          = simple_evt(OP_MODE, now);
        e.new_mode = m;
        return e;
    endfunction

    // mostly well-formed traffic for the configured nodes, with noise
    function automatic t_evt random_event();
        t_evt        e;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 85)
            event_clock = event_clock + 32'($urandom_range(15));
        else if (roll < 97)
            event_clock = event_clock + 32'($urandom_range(900));
        else
            event_clock = event_clock + $urandom();
        e.now_ms          = ($urandom_range(49) == 0) ? $urandom() : event_clock;
        e.frame_node      = 6'($urandom());
        e.frame_command   = 5'($urandom());
        e.frame_length    = 4'($urandom());
        e.frame_word_low  = $urandom();
        e.frame_byte_four = 8'($urandom());
        e.tx_direct       = 1'($urandom());
        e.new_mode        = t_mode'($urandom_range(3));
        roll = $urandom_range(99);
        if (roll < 42) begin
            e.op = OP_RX_FRAME;
            roll = $urandom_range(99);
            if (roll < 45)
                e.frame_node = active_settings.left_node;
            else if (roll < 90)
                e.frame_node = active_settings.right_node;
            roll = $urandom_range(99);
            if (roll < 55)
                e.frame_command = CMD_ENCODER;
            else if (roll < 90)
                e.frame_command = CMD_HB_REPORT;
            if ($urandom_range(99) < 80)
                e.frame_length = 4'd8;
            if ($urandom_range(99) < 80)
                e.frame_word_low = '0;
            if ($urandom_range(99) < 85)
                e.frame_byte_four = STATE_CLOSED;
        end else if (roll < 60) begin
            e.op = OP_TX_DONE;
        end else if (roll < 85) begin
            e.op = OP_POLL;
        end else if (roll < 91) begin
            e.op = OP_MODE;
        end else if (roll < 95) begin
            e.op = OP_CLEAR;
        end else if (roll < 98) begin
            e.op = OP_FORGIVE;
        end else begin
            e.op = ($urandom_range(1) == 0) ? OP_SPARE_A : OP_SPARE_B;
        end
        return e;
    endfunction

    task automatic queue_random(input int count);
        for (int k = 0; k < count; k++)
            pending_events.push_back(random_event());
    endtask

    // hold until every queued event has been answered; sampled mid-cycle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_events.size() != 0 || expected_status.size() != 0 || evt_if.valid);
    endtask

    // write all eight registers, one beat each
    task automatic program_settings(input t_sup_settings s);
        t_cfg_idx    idx;
        logic [15:0] word;
        idx = CFG_LEFT_NODE;
        @(posedge i_clk);
        do begin
            case (idx)
                CFG_LEFT_NODE:   word = {10'd0, s.left_node};
                CFG_RIGHT_NODE:  word = {10'd0, s.right_node};
                CFG_LEFT_EN:     word = {15'd0, s.left_en};
                CFG_RIGHT_EN:    word = {15'd0, s.right_en};
                CFG_FB_TIMEOUT:  word = s.fb_timeout;
                CFG_HB_TIMEOUT:  word = s.hb_timeout;
                CFG_SETTLE:      word = s.settle;
                default:         word = s.stall_limit;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= word;
            do @(posedge i_clk); while (!cfg_ready);
            idx = idx.next();
        end while (idx != CFG_LEFT_NODE);
        cfg_valid <= 1'b0;
        active_settings = s;
        settings_loaded++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // event driver: predicts status on each accepted beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : event_driver
        t_res want;
        if (!i_rst_n) begin
            evt_if.valid <= 1'b0;
        end else begin
            if (evt_if.valid && evt_if.ready) begin
                want = supervise_event(evt_if.payload);
                expected_status.push_back(want);
                events_accepted++;
                if (want.fault_dropped)
                    drops_predicted++;
                if (evt_if.payload.op == OP_POLL && want.stall_latched)
                    stalled_polls++;
            end
            if (!evt_if.valid || evt_if.ready) begin
                if (pending_events.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    evt_if.valid   <= 1'b1;
                    evt_if.payload <= pending_events.pop_front();
                end else begin
                    evt_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // status monitor with random and long output stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : status_monitor
        t_res want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                status_checked++;
                if (expected_status.size() == 0) begin
                    $error("status beat arrived with no event outstanding");
                    mismatches++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("left_healthy", 32'(want.left_healthy),
                                32'(res_if.payload.left_healthy));
                    check_field("right_healthy", 32'(want.right_healthy),
                                32'(res_if.payload.right_healthy));
                    check_field("stall_latched", 32'(want.stall_latched),
                                32'(res_if.payload.stall_latched));
                    check_field("fault_dropped", 32'(want.fault_dropped),
                                32'(res_if.payload.fault_dropped));
                    check_field("current_mode", 32'(want.current_mode),
                                32'(res_if.payload.current_mode));
                    check_field("left_error_word", want.left_error_word,
                                res_if.payload.left_error_word);
                    check_field("right_error_word", want.right_error_word,
                                res_if.payload.right_error_word);
                    check_field("all_wheels_ok", 32'(want.all_wheels_ok),
                                32'(res_if.payload.all_wheels_ok));
                end
                // long hold-offs so the block backs up into its input
                if (status_checked == 150 || status_checked == 800)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any beat moving
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timed out after %0d idle cycles", quiet_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_LEFT_NODE;
        cfg_data        = '0;
        settings_loaded = 0;
        event_clock     = 32'd2000;

        sender_idle_pct   = 29;
        receiver_idle_pct = 48;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass on reset values (left node 0, right node 1)
        pending_events.push_back(simple_evt(OP_POLL, 32'd0));
        pending_events.push_back(frame_evt(32'd10, 6'd0, CMD_ENCODER, 4'd8, '0, '0));
        // over-long frame counts as full
        pending_events.push_back(frame_evt(32'd10, 6'd1, CMD_ENCODER, 4'd15,
                                           32'hFFFF_FFFF, 8'hFF));
        pending_events.push_back(frame_evt(32'd11, 6'd1, CMD_ENCODER, 4'd7, '0, '0));
        pending_events.push_back(simple_evt(OP_POLL, 32'd20));
        pending_events.push_back(mode_evt(32'd30, MODE_VELOCITY));
        pending_events.push_back(frame_evt(32'd40, 6'd0, CMD_HB_REPORT, 4'd5, '0,
                                           STATE_CLOSED));
        pending_events.push_back(frame_evt(32'd40, 6'd1, CMD_HB_REPORT, 4'd8,
                                           32'hFFFF_FFFF, 8'hFF));
        pending_events.push_back(simple_evt(OP_POLL, 32'd50));
        // fault while already idle
        pending_events.push_back(simple_evt(OP_POLL, 32'd55));
        pending_events.push_back(simple_evt(OP_CLEAR, 32'd60));
        pending_events.push_back(frame_evt(32'd60, 6'd63, 5'd31, 4'd15,
                                           32'hFFFF_FFFF, 8'hFF));
        pending_events.push_back(tx_evt(32'd61, 1'b0));
        pending_events.push_back(tx_evt(32'd62, 1'b0));
        pending_events.push_back(tx_evt(32'd63, 1'b1));
        pending_events.push_back(mode_evt(32'd70, MODE_TORQUE));
        pending_events.push_back(frame_evt(32'd600, 6'd0, CMD_ENCODER, 4'd8, '0, '0));
        pending_events.push_back(simple_evt(OP_POLL, 32'd600));
        pending_events.push_back(simple_evt(OP_FORGIVE, 32'd700));
        pending_events.push_back(simple_evt(OP_POLL, 32'd700));
        pending_events.push_back(mode_evt(32'd710, MODE_POSITION));
        pending_events.push_back(frame_evt(32'd720, 6'd1, CMD_HB_REPORT, 4'd5, '0, 8'd3));
        pending_events.push_back(simple_evt(OP_FORGIVE, 32'd1300));
        pending_events.push_back(simple_evt(OP_POLL, 32'd1300));
        pending_events.push_back(simple_evt(OP_SPARE_A, 32'd1301));
        pending_events.push_back(simple_evt(OP_SPARE_B, 32'hFFFF_FFFF));
        pending_events.push_back(mode_evt(32'hFFFF_FFFF, MODE_IDLE));
        wait_drained();

        // typical settings, with a full drain midway
        program_settings('{left_node: 6'd5, right_node: 6'd9, left_en: 1'b1, right_en: 1'b1,
                           fb_timeout: 16'd100, hb_timeout: 16'd300, settle: 16'd200,
                           stall_limit: 16'd4});
        queue_random(150);
        wait_drained();
        queue_random(150);
        wait_drained();

        // upper extremes, shared node id, right axis disabled
        sender_idle_pct   = 48;
        receiver_idle_pct = 29;
        program_settings('{left_node: 6'd63, right_node: 6'd63, left_en: 1'b1,
                           right_en: 1'b0, fb_timeout: 16'hFFFF, hb_timeout: 16'hFFFF,
                           settle: 16'hFFFF, stall_limit: 16'hFFFF});
        queue_random(200);
        wait_drained();

        // lower extremes: zero windows, zero stall limit
        program_settings('{left_node: 6'd0, right_node: 6'd0, left_en: 1'b0, right_en: 1'b1,
                           fb_timeout: 16'd0, hb_timeout: 16'd0, settle: 16'd0,
                           stall_limit: 16'd0});
        queue_random(150);
        wait_drained();

        // tight windows across the 32-bit wrap, no idling
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        program_settings('{left_node: 6'd12, right_node: 6'd33, left_en: 1'b1, right_en: 1'b1,
                           fb_timeout: 16'd60, hb_timeout: 16'd150, settle: 16'd80,
                           stall_limit: 16'd1});
        event_clock = 32'hFFFF_F000;
        queue_random(200);
        wait_drained();

        // deferral run past the stall limit, then a direct send and a clear
        program_settings('{left_node: 6'd2, right_node: 6'd3, left_en: 1'b1, right_en: 1'b1,
                           fb_timeout: 16'd100, hb_timeout: 16'd500, settle: 16'd500,
                           stall_limit: 16'd16});
        pending_events.push_back(simple_evt(OP_CLEAR, event_clock));
        for (int k = 0; k < 18; k++)
            pending_events.push_back(tx_evt(event_clock, 1'b0));
        pending_events.push_back(simple_evt(OP_POLL, event_clock));
        pending_events.push_back(tx_evt(event_clock, 1'b1));
        pending_events.push_back(simple_evt(OP_CLEAR, event_clock));
        pending_events.push_back(simple_evt(OP_POLL, event_clock));
        wait_drained();

        repeat (10) @(posedge i_clk);
        $display("Checked %0d status beats for %0d events over %0d register settings",
                 status_checked, events_accepted, settings_loaded + 1);
        $display("Predicted %0d fault drops and %0d polls with a latched stall; %0d mismatches",
                 drops_predicted, stalled_polls, mismatches);
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
